>>> rtl/dr_pkg.sv
// Shared types and constants for the dense rank lookup block.
package dr_pkg;

  localparam int SCORE_W         = 32;
  localparam int RANK_W          = 11;
  localparam int MAX_ENTRIES_DEF = 1024;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [SCORE_W-1:0] score;
  } in_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              overflow;
  } out_t;

  typedef struct packed {
    logic              done;
    logic [RANK_W-1:0] rank;
  } srch_res_t;

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } srch_state_t;

endpackage

>>> rtl/dr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/dr_search.sv
// Binary search sequencer: one table read per cycle, next address formed from read data.
module dr_search
  import dr_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int AW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SCORE_W-1:0] query_in,
  input  logic [CW-1:0]      count,
  input  logic               slot_free,
  output logic               busy,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  logic [SCORE_W-1:0] rd_data,
  output srch_res_t          res
);

  srch_state_t        state, state_next;
  logic [CW-1:0]      lo, hi;
  logic [SCORE_W-1:0] query;
  logic [AW-1:0]      mid_q;
  logic               pend;

  logic [CW-1:0]      lo_cur, hi_cur;
  logic [CW:0]        mid_sum;
  logic [AW-1:0]      mid;
  logic               go;

  // fold in the result of the read issued last cycle
  always_comb begin
    lo_cur = lo;
    hi_cur = hi;
    if (pend) begin
      if (rd_data > query) begin
        lo_cur = CW'(mid_q) + CW'(1);
      end else begin
        hi_cur = CW'(mid_q);
      end
    end
    mid_sum = {1'b0, lo_cur} + {1'b0, hi_cur};
    mid     = mid_sum[AW:1];
    go      = lo_cur < hi_cur;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_SEARCH;
      S_SEARCH: if (!go && slot_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = mid;
    res.done = 1'b0;
    res.rank = RANK_W'(lo_cur) + RANK_W'(1);
    unique case (state)
      S_IDLE: begin
      end
      S_SEARCH: begin
        busy     = 1'b1;
        rd_en    = go;
        res.done = !go && slot_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        pend <= 1'b0;
      end else begin
        pend <= go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      if (start) begin
        lo    <= '0;
        hi    <= count;
        query <= query_in;
      end
    end else begin
      lo    <= lo_cur;
      hi    <= hi_cur;
      mid_q <= mid;
    end
  end

endmodule

>>> rtl/dense_rank_lookup.sv
// Dense rank lookup over a descending score table held in one RAM.
// Load: distinct score written at the accepting edge (overflow flagged if full); no result.
// Query: binary search with one RAM read per search step; the result waits for a free
//   output slot, and no new request is taken until the search returns to idle.
// Results sit in an output register; a waiting result does not block the next accept.
// Reset (rst, synchronous) empties the table and clears the overflow flag at once.
module dense_rank_lookup
  import dr_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int AW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic [CW-1:0]      count;
  logic [SCORE_W-1:0] last_score;
  logic               overflow_seen;

  logic               busy, accept, distinct, full, wr_en;
  logic               slot_free;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [SCORE_W-1:0] rd_data;
  srch_res_t          res;

  assign in_ready  = !busy;
  assign accept    = in_valid && in_ready;
  assign distinct  = (count == '0) || (last_score != in_data.score);
  assign full      = count == CW'(MAX_ENTRIES);
  assign wr_en     = accept && (in_data.mode == MODE_LOAD) && distinct && !full;
  assign slot_free = !out_valid || out_ready;

  dr_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[AW-1:0]),
    .wdata (in_data.score),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  dr_search #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_search (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && (in_data.mode == MODE_QUERY)),
    .query_in  (in_data.score),
    .count     (count),
    .slot_free (slot_free),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res       (res)
  );

  // entry count and sticky overflow flag; the last stored entry is registered below
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      overflow_seen <= 1'b0;
    end else if (accept && (in_data.mode == MODE_LOAD) && distinct) begin
      if (full) begin
        overflow_seen <= 1'b1;
      end else begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_score <= in_data.score;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      out_data.rank     <= res.rank;
      out_data.overflow <= overflow_seen;
    end
  end

endmodule

>>> rtl/dr_checker.sv
// Port-level checks for dense_rank_lookup, attached by bind.
module dr_checker
  import dr_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  logic ovf_reported;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf_reported <= 1'b0;
    end else if (out_valid && out_ready && out_data.overflow) begin
      ovf_reported <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_rank_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.rank != '0)
    else $error("rank of zero reported");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && ovf_reported |-> out_data.overflow)
    else $error("overflow flag cleared without reset");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.mode == MODE_QUERY) |=> !in_ready)
    else $error("request taken during a search");

endmodule

bind dense_rank_lookup dr_checker u_dr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
